[hdl/iwq_pkg.sv]
// Package for the int8 weight quantizer: shared types and constants.
// No dependencies.
package iwq_pkg;

    localparam int unsigned QMAX = 127;
    localparam int unsigned MAX_CHANNELS = 4096;

    // Configuration register indexes
    localparam logic [1:0] REG_PER_CHANNEL = 2'd0;
    localparam logic [1:0] REG_LAYOUT      = 2'd1;
    localparam logic [1:0] REG_CHAN_COUNT  = 2'd2;

    // Item classified by the front end, carried to the back end.
    typedef struct packed {
        logic        kind;
        logic [11:0] chan;
        logic [11:0] col;
        logic [15:0] wval;
        logic [15:0] wmag;
        logic [15:0] scale;
    } t_work;

endpackage

[hdl/int8_weight_quantize_tiled_layout.sv]
// Top level of the int8 weight quantizer with tiled addressing.
// Depends on iwq_pkg, iwq_front, iwq_queue, iwq_back.
// One item is accepted per cycle while o_stall is low. Each result passes
// through the front end (scale memory read), the queue, the back-end entry
// register and eight restoring-division stages. The scale store needs no
// clearing after reset. A range load reports the scale in force.
module int8_weight_quantize_tiled_layout (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic [11:0]        i_channel,
    input  logic [11:0]        i_column,
    input  logic signed [15:0] i_range_max,
    input  logic signed [15:0] i_range_min,
    input  logic signed [15:0] i_weight_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_result_kind,
    output logic [23:0]        o_dest_index,
    output logic signed [7:0]  o_quantized,
    output logic [15:0]        o_scale_out,
    output logic [11:0]        o_scale_channel
);
    logic r_per, r_layout;
    logic [12:0] r_count;
    logic f_valid, q_ready, q_valid, b_ready, front_adv;
    iwq_pkg::t_work f_work, q_work;

    assign o_cfg_ready = 1'b1;
    // Front advances only when its held item can leave
    assign front_adv = !f_valid || q_ready;
    assign o_stall = !front_adv;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per <= 1'b0; r_layout <= 1'b0; r_count <= 13'd32;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                iwq_pkg::REG_PER_CHANNEL: r_per    <= i_cfg_data[0];
                iwq_pkg::REG_LAYOUT:      r_layout <= i_cfg_data[0];
                iwq_pkg::REG_CHAN_COUNT:  r_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    iwq_front u_front (
        .i_clk, .i_rst_n, .i_valid, .i_cmd, .i_channel, .i_column,
        .i_range_max, .i_range_min, .i_weight_value,
        .i_per_channel(r_per), .i_adv(front_adv),
        .o_valid(f_valid), .o_work(f_work)
    );

    iwq_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_data(f_work), .o_ready(q_ready),
        .o_valid(q_valid), .o_data(q_work), .i_pop(b_ready)
    );

    iwq_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_work(q_work), .o_ready(b_ready),
        .i_layout(r_layout), .i_count(r_count), .o_valid, .i_stall,
        .o_kind(o_result_kind), .o_dest(o_dest_index), .o_quant(o_quantized),
        .o_scale(o_scale_out), .o_chan(o_scale_channel)
    );

    // Range results never carry a quantized value
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_kind) |-> (o_quantized == 8'sd0 && o_dest_index == 24'd0))
        else $error("range result with payload");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quantized != -8'sd128))
        else $error("quantized out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");
endmodule

[hdl/iwq_front.sv]
// Front end: scale store, range loads, scale lookup for each item.
// Depends on iwq_pkg.
module iwq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_cmd,
    input  logic [11:0]        i_channel,
    input  logic [11:0]        i_column,
    input  logic signed [15:0] i_range_max,
    input  logic signed [15:0] i_range_min,
    input  logic signed [15:0] i_weight_value,
    input  logic               i_per_channel,
    input  logic               i_adv,
    output logic               o_valid,
    output iwq_pkg::t_work     o_work
);
    logic [15:0] r_mem [0:iwq_pkg::MAX_CHANNELS-1];
    logic [15:0] r_shared;
    logic        r_valid;
    logic [15:0] r_rd;
    logic        r_fwd;
    logic [15:0] r_fwd_val;
    logic        r_per;
    logic        r_kind;
    logic [11:0] r_chan, r_col;
    logic [15:0] r_wval;
    logic [15:0] amax, amin, smax, wmag, n_shared;

    assign amax = i_range_max[15] ? 16'(-i_range_max) : i_range_max;
    assign amin = i_range_min[15] ? 16'(-i_range_min) : i_range_min;
    assign smax = (amax > amin) ? amax : amin;
    assign wmag = r_wval[15] ? 16'(-r_wval) : r_wval;
    assign n_shared = (!i_cmd && i_channel == 12'd0) ? amax : r_shared;

    // Memory: write on range load, registered read otherwise
    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            if (!i_cmd) r_mem[i_channel] <= smax;
            else r_rd <= r_mem[i_channel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_shared <= 16'd0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (i_valid) r_shared <= n_shared;
        end
    end

    // Captured payload for the lookup stage
    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_kind <= i_cmd;
            r_chan <= i_channel;
            r_col  <= i_column;
            r_wval <= i_weight_value;
            r_per  <= i_per_channel;
            r_fwd  <= !i_cmd;
            r_fwd_val <= i_per_channel ? smax : n_shared;
        end
    end

    always_comb begin
        o_valid      = r_valid;
        o_work.kind  = r_kind;
        o_work.chan  = r_chan;
        o_work.col   = r_col;
        o_work.wval  = r_wval;
        o_work.wmag  = wmag;
        o_work.scale = r_fwd ? r_fwd_val : (r_per ? r_rd : r_shared);
    end
endmodule

[hdl/iwq_queue.sv]
// Two-entry queue between front and back ends.
// Depends on iwq_pkg.
module iwq_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  iwq_pkg::t_work i_data,
    output logic           o_ready,
    output logic           o_valid,
    output iwq_pkg::t_work o_data,
    input  logic           i_pop
);
    iwq_pkg::t_work r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

[hdl/iwq_back.sv]
// Back end: pipelined divide of the scaled weight, tiled address, saturated output.
// Depends on iwq_pkg.
module iwq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  iwq_pkg::t_work i_work,
    output logic           o_ready,
    input  logic           i_layout,
    input  logic [12:0]    i_count,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_kind,
    output logic [23:0]    o_dest,
    output logic signed [7:0] o_quant,
    output logic [15:0]    o_scale,
    output logic [11:0]    o_chan
);
    // Quotient is at most 7 bits after saturation; 8 restoring steps, one per stage.
    localparam int STG = 8;
    logic             r_v   [0:STG];
    iwq_pkg::t_work   r_w   [0:STG];
    logic [25:0]      r_rem [0:STG];
    logic [7:0]       r_q   [0:STG];
    logic [23:0]      r_dst [0:STG];
    logic             adv;
    logic [25:0]      num;
    logic [4:0]       rr, rt;
    logic [9:0]       inner;
    logic [23:0]      within4, within32, mulp;

    assign adv = !r_v[STG] || !i_stall;
    assign o_ready = adv;

    // numerator 2*|w|*127 + s, divided by 2*s
    assign num = 26'({i_work.wmag, 1'b0}) * 26'(iwq_pkg::QMAX) + 26'(i_work.scale);

    // Tiled address
    assign rr = i_work.chan[4:0];
    assign rt = rr;
    assign inner = 10'({rt[2:1], rt[4:3], rt[0]});
    assign within4 = 24'((({i_work.chan[11:3], 3'b000} + {i_work.chan[0], 2'b00}
                     + 12'(i_work.col[4:3])) << 5)
                     + ((3'(i_work.col[2] ? 3'd4 : 3'd0) + 3'(i_work.chan[2:1])) << 2)
                     + i_work.col[1:0]);
    assign within32 = 24'(({7'd0, i_work.chan[11:5]} << 10) + (inner << 5)
                      + i_work.col[4:0]);
    assign mulp = 24'(i_work.col[11:5] * {i_count, 5'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= STG; i++) r_v[i] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int i = 1; i <= STG; i++) r_v[i] <= r_v[i-1];
        end
    end

    // Division stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w[0]   <= i_work;
            r_rem[0] <= num;
            r_q[0]   <= 8'd0;
            r_dst[0] <= mulp + (i_layout ? within32 : within4);
            for (int i = 1; i <= STG; i++) begin
                logic [25:0] d;
                d = 26'({r_w[i-1].scale, 1'b0}) << (STG - i);
                r_w[i]   <= r_w[i-1];
                r_dst[i] <= r_dst[i-1];
                if (r_rem[i-1] >= d) begin
                    r_rem[i] <= r_rem[i-1] - d;
                    r_q[i]   <= r_q[i-1] | (8'd1 << (STG - i));
                end else begin
                    r_rem[i] <= r_rem[i-1];
                    r_q[i]   <= r_q[i-1];
                end
            end
        end
    end

    // Saturate, sign and form result
    logic [7:0] qs;
    logic [7:0] qmag;
    always_comb begin
        qmag = (r_rem[STG] >= (26'({r_w[STG].scale, 1'b0}) << STG) || r_q[STG] > 8'd127)
               ? 8'd127 : r_q[STG];
        if (r_w[STG].wval == 16'd0) qs = 8'd0;
        else if (r_w[STG].scale == 16'd0) qs = r_w[STG].wval[15] ? 8'h81 : 8'd127;
        else qs = r_w[STG].wval[15] ? 8'(-qmag) : qmag;
        o_valid = r_v[STG];
        o_kind  = r_w[STG].kind;
        o_dest  = r_w[STG].kind ? r_dst[STG] : 24'd0;
        o_quant = r_w[STG].kind ? qs : 8'd0;
        o_scale = r_w[STG].scale;
        o_chan  = r_w[STG].chan;
    end
endmodule
